@@ rtl/pid_pkg.sv @@
// Package: PID rate loop types, constants and saturation helpers.
package pid_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_W     = 33 + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_W);
    localparam int WIDE_W    = 68;

    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [2:0] REG_INTEG_LIMIT   = 3'd3;
    localparam logic [2:0] REG_DRIVE_LIMIT   = 3'd4;
    localparam logic [2:0] REG_FILTER_TAU    = 3'd5;
    localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd6;

    localparam logic [2:0] STEP_FILT  = 3'd0;
    localparam logic [2:0] STEP_DTERM = 3'd1;
    localparam logic [2:0] STEP_IGAIN = 3'd2;
    localparam logic [2:0] STEP_IDT   = 3'd3;
    localparam logic [2:0] STEP_DRIVE = 3'd4;

    typedef struct packed {
        logic signed [31:0] setpoint;
        logic signed [31:0] measured;
        logic               high_saturated;
        logic               low_saturated;
        logic               restart;
    } pid_in_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               integration_held;
    } pid_out_t;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_DIV_RATE  = 5'b00010,
        S_DIV_ALPHA = 5'b00100,
        S_MUL       = 5'b01000,
        S_DONE      = 5'b10000
    } pid_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sh7FFFFFFF);
        lo = -WIDE_W'(64'sh80000000);
        if (x > hi)
            return 32'sh7FFFFFFF;
        else if (x < lo)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] x,
                                                    input logic [30:0] lim);
        logic signed [31:0] pos;
        logic signed [31:0] neg;
        pos = $signed({1'b0, lim});
        neg = -pos;
        if (x > pos)
            return pos;
        else if (x < neg)
            return neg;
        else
            return x;
    endfunction

endpackage

@@ rtl/pid_rate_loop_step.sv @@
// Top level: PID rate loop step with a shared multiplier and a bit-serial divider.
//
//  channel | signals                          | direction
//  in      | in_valid, in_stall, in_data      | item in
//  out     | out_valid, out_stall, out_data   | result out
//  cfg     | cfg_wr_en, cfg_index, cfg_data   | register write
//
// An item runs the one-bit-per-cycle divider up to twice (rate, filter coefficient)
// and up to five multiply steps on Q16.16 values, each a multiply phase then an
// accumulate phase; a zero sample period skips all of them.
// Reset clears config, state, loop history and out_valid but not out_data.
// in_stall is high while an item is in work; a new item is taken while a result
// still waits on a stalled output.
module pid_rate_loop_step
    import pid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  pid_in_t    in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output pid_out_t   out_data,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data
);

    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic [30:0]        ilim_reg, dlim_reg, tau_reg, dt_reg;

    pid_state_t         state_reg, state_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [31:0] filt_reg, filt_next;
    logic signed [31:0] prev_reg, prev_next;
    logic               have_prev_reg, have_prev_next;
    logic signed [31:0] e_reg, e_next;
    logic               held_reg, held_next;
    logic signed [31:0] rate_reg, rate_next;
    logic [FRAC_BITS:0] alpha_reg, alpha_next;
    logic signed [31:0] dterm_reg, dterm_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] drive_reg, drive_next;
    logic signed [65:0] p_reg, p_next;
    logic [2:0]         step_reg, step_next;
    logic               phase_reg, phase_next;
    logic [31:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [31:0]        dvs_reg, dvs_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               out_valid_reg, out_valid_next;
    pid_out_t           out_data_reg, out_data_next;

    logic               in_xfer;
    logic               out_free;
    logic signed [31:0] integ_eff, filt_eff, prev_eff;
    logic               have_eff;
    logic signed [31:0] e_acc;
    logic signed [32:0] diff_acc;
    logic [32:0]        diff_mag;
    logic [32:0]        div_sh;
    logic [33:0]        div_trial;
    logic               div_ok;
    logic [DIV_W-1:0]   quo_step;
    logic signed [WIDE_W-1:0] q_signed;
    logic signed [32:0] mul_a, mul_b;
    logic signed [WIDE_W-1:0] p_shr;
    logic signed [31:0] p_sat;
    logic [31:0]        tau_dt;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign tau_dt    = {1'b0, tau_reg} + {1'b0, dt_reg};

    assign div_sh    = {rem_reg, quo_reg[DIV_W-1]};
    assign div_trial = {1'b0, div_sh} - {2'b00, dvs_reg};
    assign div_ok    = !div_trial[33];
    assign quo_step  = {quo_reg[DIV_W-2:0], div_ok};
    assign q_signed  = neg_reg ? -WIDE_W'($signed({1'b0, quo_step}))
                               : WIDE_W'($signed({1'b0, quo_step}));

    assign p_shr = WIDE_W'(p_reg) >>> FRAC_BITS;
    assign p_sat = sat32(p_shr);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            STEP_FILT:
            begin
                mul_a = 33'($signed({1'b0, alpha_reg}));
                mul_b = 33'(rate_reg) - 33'(filt_reg);
            end
            STEP_DTERM:
            begin
                mul_a = 33'(kd_reg);
                mul_b = 33'(filt_reg);
            end
            STEP_IGAIN:
            begin
                mul_a = 33'(ki_reg);
                mul_b = 33'(e_reg);
            end
            STEP_IDT:
            begin
                mul_a = 33'(t_reg);
                mul_b = 33'($signed({1'b0, dt_reg}));
            end
            STEP_DRIVE:
            begin
                mul_a = 33'(kp_reg);
                mul_b = 33'(e_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        integ_eff = in_data.restart ? '0 : integ_reg;
        filt_eff  = in_data.restart ? '0 : filt_reg;
        prev_eff  = in_data.restart ? '0 : prev_reg;
        have_eff  = in_data.restart ? 1'b0 : have_prev_reg;
        e_acc     = sat32(WIDE_W'(in_data.setpoint) - WIDE_W'(in_data.measured));
        diff_acc  = 33'(in_data.measured) - 33'(prev_eff);
        diff_mag  = diff_acc[32] ? 33'(-diff_acc) : 33'(diff_acc);
    end

    always_comb
    begin
        state_next     = state_reg;
        integ_next     = integ_reg;
        filt_next      = filt_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        e_next         = e_reg;
        held_next      = held_reg;
        rate_next      = rate_reg;
        alpha_next     = alpha_reg;
        dterm_next     = dterm_reg;
        t_next         = t_reg;
        drive_next     = drive_reg;
        p_next         = p_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    integ_next     = integ_eff;
                    filt_next      = filt_eff;
                    prev_next      = prev_eff;
                    have_prev_next = have_eff;
                    step_next      = STEP_FILT;
                    phase_next     = 1'b0;
                    rem_next       = '0;
                    cnt_next       = '0;
                    if (dt_reg == '0)
                    begin
                        drive_next = '0;
                        held_next  = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        e_next         = e_acc;
                        held_next      = (in_data.high_saturated && e_acc > 0) ||
                                         (in_data.low_saturated && e_acc < 0);
                        prev_next      = in_data.measured;
                        have_prev_next = 1'b1;
                        if (have_eff)
                        begin
                            neg_next   = diff_acc[32];
                            quo_next   = DIV_W'(diff_mag) << FRAC_BITS;
                            dvs_next   = {1'b0, dt_reg};
                            state_next = S_DIV_RATE;
                        end
                        else
                        begin
                            rate_next = '0;
                            neg_next  = 1'b0;
                            if (tau_reg == '0)
                            begin
                                alpha_next = (FRAC_BITS+1)'(1) << FRAC_BITS;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                quo_next   = DIV_W'(dt_reg) << FRAC_BITS;
                                dvs_next   = tau_dt;
                                state_next = S_DIV_ALPHA;
                            end
                        end
                    end
                end
            end
            S_DIV_RATE:
            begin
                rem_next = div_ok ? div_trial[31:0] : div_sh[31:0];
                quo_next = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    rate_next = sat32(q_signed);
                    rem_next  = '0;
                    cnt_next  = '0;
                    neg_next  = 1'b0;
                    if (tau_reg == '0)
                    begin
                        alpha_next = (FRAC_BITS+1)'(1) << FRAC_BITS;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        quo_next   = DIV_W'(dt_reg) << FRAC_BITS;
                        dvs_next   = tau_dt;
                        state_next = S_DIV_ALPHA;
                    end
                end
            end
            S_DIV_ALPHA:
            begin
                rem_next = div_ok ? div_trial[31:0] : div_sh[31:0];
                quo_next = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    alpha_next = quo_step[FRAC_BITS:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                    p_next = mul_a * mul_b;
                else
                begin
                    step_next = step_reg + 1'b1;
                    case (step_reg)
                        STEP_FILT:
                            filt_next = sat32(WIDE_W'(filt_reg) + p_shr);
                        STEP_DTERM:
                        begin
                            dterm_next = sat32(-WIDE_W'(p_sat));
                            if (held_reg)
                                step_next = STEP_DRIVE;
                        end
                        STEP_IGAIN:
                            t_next = p_sat;
                        STEP_IDT:
                            integ_next = clamp_sym(sat32(WIDE_W'(integ_reg) +
                                                         WIDE_W'(p_sat)), ilim_reg);
                        STEP_DRIVE:
                        begin
                            drive_next = clamp_sym(sat32(WIDE_W'(p_sat) +
                                                         WIDE_W'(integ_reg) +
                                                         WIDE_W'(dterm_reg)), dlim_reg);
                            state_next = S_DONE;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.drive            = drive_reg;
                    out_data_next.integration_held = held_reg;
                    state_next                     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            ilim_reg      <= '0;
            dlim_reg      <= '0;
            tau_reg       <= '0;
            dt_reg        <= '0;
            state_reg     <= S_IDLE;
            integ_reg     <= '0;
            filt_reg      <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            step_reg      <= STEP_FILT;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:     kp_reg   <= $signed(cfg_data);
                    REG_INTEG_GAIN:    ki_reg   <= $signed(cfg_data);
                    REG_DERIV_GAIN:    kd_reg   <= $signed(cfg_data);
                    REG_INTEG_LIMIT:   ilim_reg <= cfg_data[30:0];
                    REG_DRIVE_LIMIT:   dlim_reg <= cfg_data[30:0];
                    REG_FILTER_TAU:    tau_reg  <= cfg_data[30:0];
                    REG_SAMPLE_PERIOD: dt_reg   <= cfg_data[30:0];
                    default:           ;
                endcase
            end
            state_reg     <= state_next;
            integ_reg     <= integ_next;
            filt_reg      <= filt_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg        <= e_next;
        held_reg     <= held_next;
        rate_reg     <= rate_next;
        alpha_reg    <= alpha_next;
        dterm_reg    <= dterm_next;
        t_reg        <= t_next;
        drive_reg    <= drive_next;
        p_reg        <= p_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvs_reg      <= dvs_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    // zero sample period skips all arithmetic
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && dt_reg == '0) |=> (state_reg == S_DONE))
        else $error("zero period item did not finish at once");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.drive <= $signed({1'b0, dlim_reg}) &&
                           out_data_reg.drive >= -$signed({1'b0, dlim_reg})))
        else $error("drive outside limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_RATE || state_reg == S_DIV_ALPHA) |->
            (cnt_reg < CNT_W'(DIV_W)))
        else $error("divider count overrun");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (step_reg <= STEP_DRIVE))
        else $error("multiply step out of range");

endmodule
